@@ sv/dru_pkg.sv @@
// ----------------------------------------------------------------------------
// dru_pkg
// Shared types, constants and helpers for the detector record unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package dru_pkg;

  // field widths fixed by the record format
  localparam int WORD_HIGH_W = 64;
  localparam int WORD_LOW_W  = 40;
  localparam int HIT_W       = 64;
  localparam int NARROW_W    = 12;
  localparam int TS_W        = 59;
  localparam int SYNC_TIME_W = 60;
  localparam int CNT_W       = 32;
  localparam int MARKER_W    = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  // record layout inside word_low
  localparam int NARROW_LSB = 28;
  localparam int SYNC_BIT   = 27;

  // default configuration
  localparam int DEFAULT_TIME_BITS   = 27;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [MARKER_W-1:0] HEADER_MARKER_RESET = 32'h0123_4567;
  localparam logic [MARKER_W-1:0] FOOTER_MARKER_RESET = 32'hAAAA_AAAA;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARKER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_MARKER = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SYNC    = 2'd0,
    KIND_WIDE    = 2'd1,
    KIND_NARROW  = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [WORD_HIGH_W-1:0] word_high;
    logic [WORD_LOW_W-1:0]  word_low;
  } in_item_t;

  typedef struct packed {
    kind_t                         kind;
    logic [HIT_W-1:0]              hit_bits;
    logic [TS_W-1:0]               timestamp;
    logic signed [SYNC_TIME_W-1:0] sync_time;
    logic [CNT_W-1:0]              entry_index;
    logic [CNT_W-1:0]              wide_count;
    logic [CNT_W-1:0]              narrow_count;
    logic [CNT_W-1:0]              sync_count;
    logic                          last;
  } out_item_t;

  // one classified record waiting for the back end
  // a summary carries the spill counts in the three index fields
  typedef struct packed {
    logic                          summary;
    logic                          has_sync;
    logic                          has_wide;
    logic                          has_narrow;
    logic [HIT_W-1:0]              wide_bits;
    logic [NARROW_W-1:0]           narrow_bits;
    logic [TS_W-1:0]               timestamp;
    logic signed [SYNC_TIME_W-1:0] sync_time;
    logic [CNT_W-1:0]              sync_idx;
    logic [CNT_W-1:0]              wide_idx;
    logic [CNT_W-1:0]              narrow_idx;
  } job_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ sv/dru_front.sv @@
// ----------------------------------------------------------------------------
// dru_front
// Accepts records, classifies header / footer / data, unwraps the time,
// keeps the spill counters and pushes one job per record that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module dru_front import dru_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire in_item_t               in_data,
  input  wire logic                   queue_full,
  output      logic                   push,
  output      job_t                   push_job
);

  logic [MARKER_W-1:0]           header_marker;
  logic [MARKER_W-1:0]           footer_marker;
  logic [CNT_W-1:0]              wrap_count;
  logic [TIME_BITS-1:0]          previous_raw_time;
  logic signed [SYNC_TIME_W-1:0] latest_sync_time;
  logic [CNT_W-1:0]              wide_hits_seen;
  logic [CNT_W-1:0]              narrow_hits_seen;
  logic [CNT_W-1:0]              sync_hits_seen;

  logic [MARKER_W-1:0]  top;
  logic                 is_header;
  logic                 is_footer;
  logic                 is_data;
  logic                 accept;
  logic [TIME_BITS-1:0] raw;
  logic [NARROW_W-1:0]  narrow;
  logic                 sync;
  logic                 wide_hit;
  logic                 narrow_hit;
  logic [CNT_W-1:0]     wrap_count_next;
  logic [63:0]          ts_full;
  logic [TS_W-1:0]      ts;

  // classify
  assign top        = in_data.word_high[WORD_HIGH_W-1 -: MARKER_W];
  assign is_header  = (top == header_marker);
  assign is_footer  = !is_header && (top == footer_marker);
  assign is_data    = !is_header && !is_footer;
  assign in_stall   = queue_full;
  assign accept     = in_valid && !in_stall;

  // unpack the data fields
  assign raw        = in_data.word_low[TIME_BITS-1:0];
  assign narrow     = in_data.word_low[NARROW_LSB +: NARROW_W];
  assign sync       = in_data.word_low[SYNC_BIT];
  assign wide_hit   = (in_data.word_high != '0);
  assign narrow_hit = (narrow != '0);

  // time unwrap: a decrease of the raw time counts one wrap
  assign wrap_count_next = (raw < previous_raw_time) ? sat_inc(wrap_count) : wrap_count;
  assign ts_full         = (64'(wrap_count_next) << TIME_BITS) | 64'(raw);
  assign ts              = ts_full[TS_W-1:0];

  // job for the back end
  assign push = accept && (is_footer || (is_data && (sync || wide_hit || narrow_hit)));

  always_comb begin
    push_job             = '0;
    push_job.summary     = is_footer;
    push_job.has_sync    = is_data && sync;
    push_job.has_wide    = is_data && wide_hit;
    push_job.has_narrow  = is_data && narrow_hit;
    push_job.wide_bits   = in_data.word_high;
    push_job.narrow_bits = narrow;
    push_job.timestamp   = ts;
    push_job.sync_time   = (is_data && sync) ? $signed({1'b0, ts}) : latest_sync_time;
    if (is_footer) begin
      push_job.sync_idx   = sync_hits_seen;
      push_job.wide_idx   = wide_hits_seen;
      push_job.narrow_idx = narrow_hits_seen;
    end else begin
      push_job.sync_idx   = sync_hits_seen;
      push_job.wide_idx   = wide_hits_seen;
      push_job.narrow_idx = narrow_hits_seen;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_marker <= HEADER_MARKER_RESET;
      footer_marker <= FOOTER_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_MARKER: header_marker <= cfg_data[MARKER_W-1:0];
        REG_FOOTER_MARKER: footer_marker <= cfg_data[MARKER_W-1:0];
        default: ;
      endcase
    end
  end

  // spill state
  always_ff @(posedge clk) begin
    if (rst || (accept && is_header)) begin
      wrap_count        <= '0;
      previous_raw_time <= '0;
      latest_sync_time  <= '1;
      wide_hits_seen    <= '0;
      narrow_hits_seen  <= '0;
      sync_hits_seen    <= '0;
    end else if (accept && is_data) begin
      wrap_count        <= wrap_count_next;
      previous_raw_time <= raw;
      if (sync) begin
        latest_sync_time <= $signed({1'b0, ts});
        sync_hits_seen   <= sat_inc(sync_hits_seen);
      end
      if (wide_hit) begin
        wide_hits_seen <= sat_inc(wide_hits_seen);
      end
      if (narrow_hit) begin
        narrow_hits_seen <= sat_inc(narrow_hits_seen);
      end
    end
  end

`ifndef ASSERT_OFF
  // the sync time is either none or a 59-bit timestamp
  a_sync_time_form: assert property (@(posedge clk) disable iff (rst)
    latest_sync_time[SYNC_TIME_W-1] |-> (&latest_sync_time))
    else $error("latest sync time has an invalid form");

  // a footer leaves the spill state alone
  a_footer_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && is_footer && !cfg_we) |=> ($stable(wrap_count) && $stable(sync_hits_seen)
      && $stable(wide_hits_seen) && $stable(narrow_hits_seen)))
    else $error("footer changed spill state");

  // no job is pushed into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

@@ sv/dru_queue.sv @@
// ----------------------------------------------------------------------------
// dru_queue
// Short job queue between front and back end, flip-flop storage.
// ----------------------------------------------------------------------------
`default_nettype none

module dru_queue import dru_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output      logic full,
  input  wire logic pop,
  output      job_t head,
  output      logic empty
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  job_t               entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == COUNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dru_back.sv @@
// ----------------------------------------------------------------------------
// dru_back
// Walks the head job one result per cycle (sync, wide, narrow or summary)
// into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dru_back import dru_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire job_t      head,
  input  wire logic      empty,
  output      logic      pop,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  logic [2:0] served;
  logic [2:0] pending;
  logic [2:0] sel;
  logic       sel_last;
  logic       load;
  logic       emit;
  out_item_t  result;

  // results still owed for the head job, in order sync, wide, narrow
  assign pending = {head.has_narrow, head.has_wide, head.has_sync} & ~served;
  assign sel[0]  = pending[0];
  assign sel[1]  = !pending[0] && pending[1];
  assign sel[2]  = !pending[0] && !pending[1] && pending[2];
  assign sel_last = head.summary || ((pending & ~sel) == '0);

  assign load = !out_valid || !out_stall;
  assign emit = load && !empty;
  assign pop  = emit && sel_last;

  // build the next result
  always_comb begin
    result           = '0;
    result.timestamp = head.timestamp;
    result.sync_time = head.sync_time;
    result.last      = sel_last;
    if (head.summary) begin
      result.kind         = KIND_SUMMARY;
      result.timestamp    = '0;
      result.wide_count   = head.wide_idx;
      result.narrow_count = head.narrow_idx;
      result.sync_count   = head.sync_idx;
    end else if (sel[0]) begin
      result.kind        = KIND_SYNC;
      result.hit_bits    = HIT_W'(1);
      result.entry_index = head.sync_idx;
    end else if (sel[1]) begin
      result.kind        = KIND_WIDE;
      result.hit_bits    = head.wide_bits;
      result.entry_index = head.wide_idx;
    end else begin
      result.kind        = KIND_NARROW;
      result.hit_bits    = HIT_W'(head.narrow_bits);
      result.entry_index = head.narrow_idx;
    end
  end

  // progress through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      served <= '0;
    end else if (emit) begin
      served <= sel_last ? '0 : (served | sel);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // only results the head job carries are marked served
  a_served_subset: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((served & ~{head.has_narrow, head.has_wide, head.has_sync}) == '0))
    else $error("served mask holds a result the job lacks");

  // nothing is half served while the queue is empty
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    empty |-> (served == '0))
    else $error("served mask set with empty queue");

  // a job is kept until its last result has gone out
  a_job_kept: assert property (@(posedge clk) disable iff (rst)
    (emit && !sel_last) |=> !empty)
    else $error("job lost before its last result");
`endif

endmodule

`default_nettype wire

@@ sv/detector_record_unpacker_unit.sv @@
// ----------------------------------------------------------------------------
// detector_record_unpacker_unit
// Unpacks 104-bit detector records into sync, wide, narrow hit results and
// spill summaries.
// ----------------------------------------------------------------------------
// The front end takes one record per cycle whenever its job queue has room,
// decodes it, unwraps the time and updates the spill counters at once; a
// header or a data record without hits leaves no job. The back end sends one
// result per cycle from the queue head through an output register while the
// output is not stalled, so a record with one to three results holds the
// queue head until its last result has gone out. The first result of a
// record passes through the job queue and then the output register.
// Configuration writes take effect at the next edge and are meant for
// idle periods only.
`default_nettype none

module detector_record_unpacker_unit import dru_pkg::*; #(
  parameter int TIME_BITS   = DEFAULT_TIME_BITS,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire in_item_t               in_data,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      out_item_t              out_data
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t head;
  logic empty;

  // decode and spill state
  dru_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  // job queue
  dru_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // result sequencing
  dru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for detector_record_unpacker_unit: a directed table of
// records and marker writes, then mostly framed spills of random data records under
// four marker settings, with random gaps and stalls on both channels and one
// long output hold-off. Every output beat is checked against a local model or a directed expected value.
// ----------------------------------------------------------------------------

module tb;
  import dru_pkg::*;

  localparam int TIME_BITS = DEFAULT_TIME_BITS;
  // watchdog limit lies well above the slowest beat spacing and the long hold-off
  localparam int LIMIT     = 2000;
  localparam int LONG_HOLD = 150;

  typedef enum logic [1:0] {
    ROW_RECORD  = 2'd0,
    ROW_SET_REG = 2'd1
  } row_op_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } row_chk_t;

  typedef struct packed {
    row_op_t                op;
    row_chk_t               chk;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_item_t               rec;
    out_item_t              want;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;

  // model state: markers and spill state
  logic [MARKER_W-1:0]           hdr_mark;
  logic [MARKER_W-1:0]           ftr_mark;
  logic [CNT_W-1:0]              wraps;
  logic [TIME_BITS-1:0]          prev_raw;
  logic signed [SYNC_TIME_W-1:0] last_sync;
  logic [CNT_W-1:0]              spill_wide;
  logic [CNT_W-1:0]              spill_narrow;
  logic [CNT_W-1:0]              spill_sync;

  out_item_t record_results[$];
  out_item_t pending_results[$];
  out_item_t head_result;

  // stimulus state
  logic [TIME_BITS-1:0] gen_raw;
  bit                   tx_idling;
  bit                   rx_idling;
  bit                   hold_req;

  int n_records;
  int n_results;
  int n_mismatch;
  int n_by_kind[4];
  int idle_cycles;

  detector_record_unpacker_unit #(
    .TIME_BITS(TIME_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // spill state back to its cleared values
  function automatic void clear_spill_state();
    wraps        = '0;
    prev_raw     = '0;
    last_sync    = '1;
    spill_wide   = '0;
    spill_narrow = '0;
    spill_sync   = '0;
  endfunction

  // results of one record, in output order, into record_results
  function automatic void unpack_record(input in_item_t rec);
    logic [MARKER_W-1:0]  top;
    logic [TIME_BITS-1:0] raw;
    logic [TS_W-1:0]      ts;
    logic [HIT_W-1:0]     narrow;
    out_item_t            r;
    top = rec.word_high[WORD_HIGH_W-1 -: MARKER_W];
    record_results.delete();
    if (top == hdr_mark) begin
      clear_spill_state();
      return;
    end
    r = '0;
    if (top == ftr_mark) begin
      r.kind         = KIND_SUMMARY;
      r.sync_time    = last_sync;
      r.wide_count   = spill_wide;
      r.narrow_count = spill_narrow;
      r.sync_count   = spill_sync;
      r.last         = 1'b1;
      record_results.push_back(r);
      return;
    end

    // time unwrap: each decrease of the raw time is one wrap
    raw = rec.word_low[TIME_BITS-1:0];
    if (raw < prev_raw && wraps != '1)
      wraps++;
    prev_raw    = raw;
    ts          = TS_W'(raw) + (TS_W'(wraps) << TIME_BITS);
    r.timestamp = ts;
    narrow      = HIT_W'(rec.word_low[NARROW_LSB +: NARROW_W]);

    if (rec.word_low[SYNC_BIT]) begin
      last_sync     = SYNC_TIME_W'(ts);
      r.kind        = KIND_SYNC;
      r.hit_bits    = HIT_W'(1);
      r.sync_time   = last_sync;
      r.entry_index = spill_sync;
      record_results.push_back(r);
      if (spill_sync != '1)
        spill_sync++;
    end
    if (rec.word_high != '0) begin
      r.kind        = KIND_WIDE;
      r.hit_bits    = rec.word_high;
      r.sync_time   = last_sync;
      r.entry_index = spill_wide;
      record_results.push_back(r);
      if (spill_wide != '1)
        spill_wide++;
    end
    if (narrow != '0) begin
      r.kind        = KIND_NARROW;
      r.hit_bits    = narrow;
      r.sync_time   = last_sync;
      r.entry_index = spill_narrow;
      record_results.push_back(r);
      if (spill_narrow != '1)
        spill_narrow++;
    end
    if (record_results.size() > 0) begin
      r = record_results.pop_back();
      r.last = 1'b1;
      record_results.push_back(r);
    end
  endfunction

  function automatic row_t rec_row(input row_chk_t chk, input logic [63:0] hi,
                                   input logic [39:0] lo, input out_item_t want);
    row_t r;
    r = '0;
    r.op             = ROW_RECORD;
    r.chk            = chk;
    r.rec.word_high  = hi;
    r.rec.word_low   = lo;
    r.want           = want;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '0;
    r.op      = ROW_SET_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // data record with random hits; raw time mostly climbs, sometimes jumps
  function automatic in_item_t make_data();
    in_item_t            rec;
    logic [MARKER_W-1:0] top;
    logic [11:0]         narrow;
    logic                sync_bit;
    if ($urandom_range(0, 5) == 0)
      gen_raw = TIME_BITS'($urandom);
    else
      gen_raw = gen_raw + TIME_BITS'($urandom_range(0, 1 << 22));
    do
      top = $urandom;
    while (top == hdr_mark || top == ftr_mark);
    rec.word_high = ($urandom_range(0, 1) == 1) ? {top, 32'($urandom)} : '0;
    if ($urandom_range(0, 7) == 0)
      rec.word_high = {32'h0, 32'($urandom)};
    narrow   = ($urandom_range(0, 1) == 1) ? 12'($urandom) : 12'h0;
    sync_bit = ($urandom_range(0, 2) == 0);
    rec.word_low = {narrow, sync_bit, gen_raw};
    return rec;
  endfunction

  // offer one record, hold it until accepted, then log its expectations
  task automatic send_record(input in_item_t rec, input row_chk_t chk,
                             input out_item_t want);
    @(negedge clk);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rec;
    do
      @(posedge clk);
    while (in_stall);
    n_records++;
    unpack_record(rec);
    case (chk)
      CHK_MODEL: foreach (record_results[i]) pending_results.push_back(record_results[i]);
      CHK_ONE:   pending_results.push_back(want);
      default:   ;
    endcase
  endtask

  // drop valid and wait for the block to drain
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a record without results may still be in flight
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_HEADER_MARKER)
      hdr_mark = val;
    else
      ftr_mark = val;
  endtask

  // mostly framed spills, with some unframed data, stray footers and junk
  task automatic run_spills(input int count);
    int       stop;
    in_item_t rec;
    stop = n_records + count;
    while (n_records < stop) begin
      if ($urandom_range(0, 6) != 0) begin
        rec.word_high = {hdr_mark, 32'($urandom)};
        rec.word_low  = 40'({$urandom, $urandom});
        send_record(rec, CHK_MODEL, '0);
        repeat ($urandom_range(1, 8)) send_record(make_data(), CHK_MODEL, '0);
        rec.word_high = {ftr_mark, 32'($urandom)};
        rec.word_low  = 40'({$urandom, $urandom});
        send_record(rec, CHK_MODEL, '0);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            rec.word_high = {$urandom, $urandom};
            rec.word_low  = 40'({$urandom, $urandom});
            send_record(rec, CHK_MODEL, '0);
          end
          1: repeat ($urandom_range(1, 4)) send_record(make_data(), CHK_MODEL, '0);
          default: begin
            rec.word_high = {ftr_mark, 32'($urandom)};
            rec.word_low  = 40'({$urandom, $urandom});
            send_record(rec, CHK_MODEL, '0);
          end
        endcase
      end
    end
  endtask

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // output check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      n_by_kind[out_data.kind]++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected beat: kind %0d hits %h ts %h last %b",
                   out_data.kind, out_data.hit_bits, out_data.timestamp, out_data.last);
      end else begin
        head_result = pending_results.pop_front();
        if (out_data.kind !== head_result.kind ||
            out_data.hit_bits !== head_result.hit_bits ||
            out_data.timestamp !== head_result.timestamp ||
            out_data.sync_time !== head_result.sync_time ||
            out_data.entry_index !== head_result.entry_index ||
            out_data.wide_count !== head_result.wide_count ||
            out_data.narrow_count !== head_result.narrow_count ||
            out_data.sync_count !== head_result.sync_count ||
            out_data.last !== head_result.last) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch at beat %0d (expected / actual):", n_results);
            $display("  kind %0d/%0d hits %h/%h ts %h/%h sync %0d/%0d",
                     head_result.kind, out_data.kind, head_result.hit_bits,
                     out_data.hit_bits, head_result.timestamp, out_data.timestamp,
                     head_result.sync_time, out_data.sync_time);
            $display("  idx %0d/%0d wide %0d/%0d narrow %0d/%0d sync %0d/%0d last %b/%b",
                     head_result.entry_index, out_data.entry_index,
                     head_result.wide_count, out_data.wide_count,
                     head_result.narrow_count, out_data.narrow_count,
                     head_result.sync_count, out_data.sync_count,
                     head_result.last, out_data.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t                plan[$];
    out_item_t           blank_summary;
    out_item_t           first_sync;
    logic [MARKER_W-1:0] mark_a;
    logic [MARKER_W-1:0] mark_b;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    hold_req  = 1'b0;
    gen_raw   = '0;
    n_records  = 0;
    n_results  = 0;
    n_mismatch = 0;
    idle_cycles = 0;
    foreach (n_by_kind[i]) n_by_kind[i] = 0;
    hdr_mark = HEADER_MARKER_RESET;
    ftr_mark = FOOTER_MARKER_RESET;
    clear_spill_state();

    // summary of an empty spill, and the first sync hit after reset
    blank_summary           = '0;
    blank_summary.kind      = KIND_SUMMARY;
    blank_summary.sync_time = '1;
    blank_summary.last      = 1'b1;
    first_sync              = '0;
    first_sync.kind         = KIND_SYNC;
    first_sync.hit_bits     = HIT_W'(1);
    first_sync.timestamp    = TS_W'(5);
    first_sync.sync_time    = SYNC_TIME_W'(5);
    first_sync.last         = 1'b1;

    // directed table
    plan.push_back(rec_row(CHK_ONE, {FOOTER_MARKER_RESET, 32'h0}, '0, blank_summary));
    plan.push_back(rec_row(CHK_ONE, '0, {12'h0, 1'b1, 27'd5}, first_sync));
    plan.push_back(rec_row(CHK_MODEL, '1, '1, '0));
    plan.push_back(rec_row(CHK_MODEL, 64'h1, {12'h800, 1'b0, 27'd0}, '0));
    plan.push_back(rec_row(CHK_NONE, '0, {12'h0, 1'b0, 27'd3}, '0));
    plan.push_back(rec_row(CHK_MODEL, '0, {12'h001, 1'b0, 27'd2}, '0));
    plan.push_back(rec_row(CHK_MODEL, {32'h0123_4566, 32'h0}, 40'd100, '0));
    plan.push_back(rec_row(CHK_MODEL, {32'hAAAA_AAAB, 32'hFFFF_FFFF}, 40'd150, '0));
    plan.push_back(rec_row(CHK_MODEL, {FOOTER_MARKER_RESET, 32'h1}, '0, '0));
    plan.push_back(rec_row(CHK_NONE, {HEADER_MARKER_RESET, 32'h89AB_CDEF}, '1, '0));
    plan.push_back(rec_row(CHK_ONE, {FOOTER_MARKER_RESET, 32'h0}, '1, blank_summary));
    plan.push_back(reg_row(REG_HEADER_MARKER, 32'h0));
    plan.push_back(reg_row(REG_FOOTER_MARKER, 32'hFFFF_FFFF));
    plan.push_back(rec_row(CHK_NONE, {32'h0, 32'hDEAD_BEEF}, '0, '0));
    plan.push_back(rec_row(CHK_ONE, {32'hFFFF_FFFF, 32'h0}, '0, blank_summary));
    plan.push_back(rec_row(CHK_MODEL, {32'h8000_0000, 32'h1}, {12'hFFF, 1'b1, 27'd1}, '0));
    plan.push_back(rec_row(CHK_MODEL, '1, '0, '0));
    // equal markers: header takes priority
    plan.push_back(reg_row(REG_HEADER_MARKER, 32'h5A5A_5A5A));
    plan.push_back(reg_row(REG_FOOTER_MARKER, 32'h5A5A_5A5A));
    plan.push_back(rec_row(CHK_NONE, {32'h5A5A_5A5A, 32'h0}, '0, '0));
    plan.push_back(rec_row(CHK_MODEL, {32'h5A5A_5A5B, 32'h0}, {12'h03C, 1'b1, 27'h400_0000},
                           '0));
    plan.push_back(reg_row(REG_HEADER_MARKER, HEADER_MARKER_RESET));
    plan.push_back(reg_row(REG_FOOTER_MARKER, FOOTER_MARKER_RESET));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_SET_REG)
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        send_record(plan[i].rec, plan[i].chk, plan[i].want);
    end

    // random spills under reset markers
    run_spills(70);

    // extreme markers, output held off long enough to back up the input
    set_reg(REG_HEADER_MARKER, 32'h0);
    set_reg(REG_FOOTER_MARKER, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_spills(70);

    // random distinct markers
    mark_a = $urandom;
    do
      mark_b = $urandom;
    while (mark_b == mark_a);
    set_reg(REG_HEADER_MARKER, mark_a);
    set_reg(REG_FOOTER_MARKER, mark_b);
    run_spills(70);

    // equal markers, full rate on both sides
    set_reg(REG_FOOTER_MARKER, mark_a);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    run_spills(70);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d records and %0d result beats: sync %0d, wide %0d, narrow %0d, "
             , n_records, n_results, n_by_kind[KIND_SYNC], n_by_kind[KIND_WIDE],
             n_by_kind[KIND_NARROW]);
    $display("summary %0d; four marker settings incl. extremes and equal, one long hold-off",
             n_by_kind[KIND_SUMMARY]);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_mismatch, pending_results.size());
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
